FILE: sv/fsc_pkg.sv
// fsc_pkg: shared types and constants for the frustum sphere culler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package fsc_pkg;
  localparam int DEF_COORD_WIDTH = 32;
  localparam int PLANE_COUNT = 6;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_REBUILD = 2'd1,
    KIND_TEST    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  // one queued command between front and back
  typedef struct packed {
    kind_t        kind;
    logic [3:0]   element_index;
    logic [31:0]  element_value;
    logic [31:0]  center_x;
    logic [31:0]  center_y;
    logic [31:0]  center_z;
    logic [30:0]  sphere_radius;
  } cmd_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_TEST, BK_RB_FETCH, BK_RB_SCALE, BK_RB_SQ, BK_RB_SQRT,
    BK_RB_DIV, BK_RB_STORE
  } bk_state_t;
endpackage
`default_nettype wire

FILE: sv/fsc_queue.sv
// fsc_queue: two-entry command queue between front and back
// depends on fsc_pkg
`timescale 1ns / 1ps
`default_nettype none
module fsc_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire fsc_pkg::cmd_t push_cmd,
  input  wire logic         pop,
  output fsc_pkg::cmd_t     head,
  output logic              not_empty,
  output logic              full
);
  import fsc_pkg::*;
  cmd_t mem [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0; wr_ptr <= 1'b0; count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
  assign head = mem[rd_ptr];
  assign not_empty = (count != 2'd0);
  assign full = (count == 2'd2);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
endmodule
`default_nettype wire

FILE: sv/fsc_back.sv
// fsc_back: matrix store, plane rebuild sequencer and sphere tester
// depends on fsc_pkg
`timescale 1ns / 1ps
`default_nettype none
module fsc_back #(
  parameter int COORD_WIDTH = fsc_pkg::DEF_COORD_WIDTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire fsc_pkg::cmd_t cmd,
  input  wire logic          cmd_valid,
  output logic               cmd_pop,
  output logic               done,
  output logic               visible
);
  import fsc_pkg::*;
  localparam int OFFSET_BITS = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam logic [33:0] HALF = 34'd1 << (OFFSET_BITS - 1);

  logic [31:0] mat [16];
  logic [31:0] nrm [18];
  logic [31:0] ofs [6];

  bk_state_t state, state_next;
  logic [2:0] plane;
  logic [1:0] k;           // component index for square / divide
  logic [5:0] step;        // sqrt / divide phase flag

  // rebuild datapath registers
  logic signed [33:0] comp [4];
  logic [33:0] mag [4];
  logic [5:0]  sh_up, sh_down;
  logic [32:0] scaled [3];
  logic [65:0] sum;
  logic [65:0] sq_x, sq_res, sq_bit;
  logic [31:0] len;
  logic [80:0] dnum;
  logic [32:0] drem;
  logic [33:0] dq;
  logic [6:0]  dcnt;
  logic [33:0] dcap;

  // plane row selection
  logic [1:0] row;
  logic       plus;
  always_comb begin
    case (plane)
      3'd0: begin row = 2'd0; plus = 1'b0; end
      3'd1: begin row = 2'd0; plus = 1'b1; end
      3'd2: begin row = 2'd1; plus = 1'b1; end
      3'd3: begin row = 2'd1; plus = 1'b0; end
      3'd4: begin row = 2'd2; plus = 1'b0; end
      default: begin row = 2'd2; plus = 1'b1; end
    endcase
  end

  // test path: one plane per cycle
  logic signed [63:0] p0, p1, p2;
  logic signed [66:0] tsum, tlim;
  logic [4:0] nb;
  always_comb begin
    nb = 5'(plane) * 5'd3;
    p0 = $signed(nrm[nb]) * $signed(cmd.center_x);
    p1 = $signed(nrm[5'(nb + 5'd1)]) * $signed(cmd.center_y);
    p2 = $signed(nrm[5'(nb + 5'd2)]) * $signed(cmd.center_z);
    tsum = 67'(p0) + 67'(p1) + 67'(p2) + ($signed(67'($signed(ofs[plane]))) <<< 30);
    tlim = -($signed({36'd0, cmd.sphere_radius}) <<< 30);
  end

  // max magnitude and normalize shift, taken from the fetched components
  logic [33:0] cmag [3];
  logic [33:0] mx;
  logic [5:0]  lz;
  always_comb begin
    for (int i = 0; i < 3; i++) cmag[i] = comp[i][33] ? 34'(-comp[i]) : 34'(comp[i]);
    mx = cmag[0];
    if (cmag[1] > mx) mx = cmag[1];
    if (cmag[2] > mx) mx = cmag[2];
    lz = 6'd0;
    for (int i = 0; i < 34; i++) if (mx[i]) lz = 6'(33 - i);
  end

  // sqrt step
  logic [65:0] sq_trial;
  assign sq_trial = sq_res + sq_bit;

  // divide step
  logic [33:0] dr_sh;
  logic        dbit;
  logic [6:0]  didx;
  assign didx = dcnt - 7'd1;
  assign dbit = dnum[didx];
  assign dr_sh = {drem, dbit};

  logic [33:0] dnum_mag;
  logic [6:0]  dexp;
  always_comb begin
    dnum_mag = (k == 2'd3) ? mag[3] : {1'b0, scaled[k[1] ? 2'd2 : {1'b0, k[0]}]};
    dexp = (k == 2'd3) ? 7'(7'd16 + 7'(sh_up) - 7'(sh_down)) : 7'd30;
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (cmd_valid) begin
        case (cmd.kind)
          KIND_TEST:    state_next = BK_TEST;
          KIND_REBUILD: state_next = BK_RB_FETCH;
          default:      state_next = BK_IDLE;
        endcase
      end
      BK_TEST: if (tsum < tlim || plane == 3'(PLANE_COUNT - 1)) state_next = BK_IDLE;
      BK_RB_FETCH: state_next = BK_RB_SCALE;
      BK_RB_SCALE: state_next = (mx == 34'd0) ? BK_RB_STORE : BK_RB_SQ;
      BK_RB_SQ: if (k == 2'd2) state_next = BK_RB_SQRT;
      BK_RB_SQRT: if (sq_bit == 66'd0) state_next = BK_RB_DIV;
      BK_RB_DIV: if (dcnt == 7'd0 && step == 6'd2 && k == 2'd3) state_next = BK_RB_STORE;
      BK_RB_STORE: state_next = (plane == 3'(PLANE_COUNT - 1)) ? BK_IDLE : BK_RB_FETCH;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = 1'b0;
    case (state)
      BK_IDLE: cmd_pop = cmd_valid && cmd.kind != KIND_TEST && cmd.kind != KIND_REBUILD;
      BK_TEST: cmd_pop = (tsum < tlim) || plane == 3'(PLANE_COUNT - 1);
      BK_RB_STORE: cmd_pop = (plane == 3'(PLANE_COUNT - 1));
      default: cmd_pop = 1'b0;
    endcase
  end

  logic [33:0] qr;
  always_comb begin
    qr = (dq > dcap) ? dcap : dq;
    if (dq <= dcap && {drem, 1'b0} >= {1'b0, 1'b0, len}) qr = dq + 34'd1;
    if (qr > dcap) qr = dcap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE; plane <= 3'd0; k <= 2'd0; done <= 1'b0; visible <= 1'b0;
      for (int i = 0; i < 16; i++) mat[i] <= 32'd0;
      for (int i = 0; i < 18; i++) nrm[i] <= 32'd0;
      for (int i = 0; i < 6; i++) ofs[i] <= 32'd0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      case (state)
        BK_IDLE: begin
          plane <= 3'd0;
          if (cmd_valid && cmd.kind == KIND_LOAD) mat[cmd.element_index] <= cmd.element_value;
        end
        BK_TEST: begin
          plane <= plane + 3'd1;
          if (tsum < tlim) begin done <= 1'b1; visible <= 1'b0; end
          else if (plane == 3'(PLANE_COUNT - 1)) begin done <= 1'b1; visible <= 1'b1; end
        end
        BK_RB_FETCH: begin
          for (int c = 0; c < 4; c++) begin
            comp[c] <= plus ? 34'($signed(mat[3 + 4 * c])) + 34'($signed(mat[row + 4 * c]))
                            : 34'($signed(mat[3 + 4 * c])) - 34'($signed(mat[row + 4 * c]));
          end
          k <= 2'd0;
        end
        BK_RB_SCALE: begin
          for (int c = 0; c < 4; c++) mag[c] <= comp[c][33] ? 34'(-comp[c]) : 34'(comp[c]);
          if (lz >= 6'd3) begin sh_up <= lz - 6'd3; sh_down <= 6'd0; end
          else begin sh_up <= 6'd0; sh_down <= 6'd3 - lz; end
          sum <= 66'd0;
        end
        BK_RB_SQ: begin
          scaled[k] <= 33'((sh_up != 6'd0) ? (mag[k] << sh_up) : (mag[k] >> sh_down));
          if (k != 2'd0) sum <= sum + 66'(scaled[k - 2'd1]) * 66'(scaled[k - 2'd1]);
          k <= k + 2'd1;
          if (k == 2'd2) begin
            sq_res <= 66'd0; sq_bit <= 66'd1 << 64; sq_x <= 66'd0; step <= 6'd0;
          end
        end
        BK_RB_SQRT: begin
          if (step == 6'd0) begin
            sq_x <= sum + 66'(scaled[2]) * 66'(scaled[2]);
            step <= 6'd1;
          end else begin
            if (sq_x >= sq_trial) begin
              sq_x <= sq_x - sq_trial; sq_res <= (sq_res >> 1) + sq_bit;
            end else sq_res <= sq_res >> 1;
            sq_bit <= sq_bit >> 2;
            if (sq_bit == 66'd0) begin
              len <= sq_res[31:0]; k <= 2'd0; dcnt <= 7'd0;
            end
          end
        end
        BK_RB_DIV: begin
          if (dcnt == 7'd0 && step != 6'd2) begin
            dnum <= 81'(dnum_mag) << dexp;
            dcnt <= 7'(7'd34 + dexp);
            drem <= 33'd0; dq <= 34'd0;
            dcap <= (k == 2'd3) ? (comp[3][33] ? HALF : HALF - 34'd1) : 34'd1 << 30;
            step <= 6'd2;
          end else if (dcnt != 7'd0) begin
            dcnt <= dcnt - 7'd1;
            if (dr_sh >= {2'b0, len}) begin
              drem <= 33'(dr_sh - {2'b0, len});
              dq <= ((dq << 1) | 34'd1) > dcap ? dcap + 34'd1 : ((dq << 1) | 34'd1);
            end else begin
              drem <= dr_sh[32:0];
              dq <= (dq << 1) > dcap ? dcap + 34'd1 : (dq << 1);
            end
          end else begin
            step <= 6'd0;
            if (k == 2'd3)
              ofs[plane] <= comp[3][33] ? 32'(-qr) : 32'(qr);
            else
              nrm[5'(plane) * 5'd3 + 5'(k)] <= comp[k][33] ? 32'(-qr) : 32'(qr);
            k <= k + 2'd1;
          end
        end
        BK_RB_STORE: begin
          if (mx == 34'd0) begin
            for (int c = 0; c < 3; c++) nrm[5'(plane) * 5'd3 + 5'(c)] <= 32'd0;
            if (comp[3][33]) ofs[plane] <= 32'(-((mag[3] > HALF) ? HALF : mag[3]));
            else ofs[plane] <= 32'((mag[3] > HALF - 34'd1) ? HALF - 34'd1 : mag[3]);
          end
          plane <= plane + 3'd1;
        end
        default: ;
      endcase
    end
  end

  a_plane_range: assert property (@(posedge clk) disable iff (rst)
    state == BK_TEST |-> plane < 3'(PLANE_COUNT)) else $error("plane index out of range");
  a_done_from_test: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == BK_TEST) else $error("result outside a test");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid) else $error("pop without command");
endmodule
`default_nettype wire

FILE: sv/frustum_sphere_cull.sv
// frustum_sphere_cull: top level, command front end with queue to the back end
// depends on fsc_pkg, fsc_queue, fsc_back
`timescale 1ns / 1ps
`default_nettype none
// usage
// - raise start with kind and the payload ports for one cycle while busy is low;
//   the transaction is taken at that edge
// - kind load writes one column-major matrix element, kind rebuild derives the
//   six normalized planes, kind test checks one sphere, unused kind is dropped
// - only tests give a result: done pulses for one cycle with visible valid
// - the receiver cannot stall: done is a single-cycle strobe
// - a test computes one plane dot product per cycle in the back end,
//   stopping at the first plane that rejects the sphere
// - a rebuild's length per plane is set by the bit-serial square root (33 steps)
//   and the four restoring divides per plane (64 steps for each normal
//   component, up to 80 for the offset)
// - a load is written into the matrix store as it is popped; an unused kind never reaches the back end
// - a two-entry queue decouples the front end: busy is high only while it is full
// - reset clears matrix, planes, queue and state; tests before a rebuild see
//   all-zero planes and report visible
module frustum_sphere_cull #(
  parameter int COORD_WIDTH = fsc_pkg::DEF_COORD_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  kind,
  input  wire logic [3:0]  element_index,
  input  wire logic [31:0] element_value,
  input  wire logic [31:0] center_x,
  input  wire logic [31:0] center_y,
  input  wire logic [31:0] center_z,
  input  wire logic [30:0] sphere_radius,
  output logic             done,
  output logic             visible
);
  import fsc_pkg::*;
  cmd_t in_cmd, head;
  logic q_full, q_valid, q_pop, push;

  // front end: pack the transaction and classify its kind
  always_comb begin
    in_cmd.kind = kind_t'(kind);
    in_cmd.element_index = element_index;
    in_cmd.element_value = element_value;
    in_cmd.center_x = center_x;
    in_cmd.center_y = center_y;
    in_cmd.center_z = center_z;
    in_cmd.sphere_radius = sphere_radius;
  end
  assign busy = q_full;
  // unused kind never enters the queue
  assign push = start && !busy && kind_t'(kind) != KIND_NONE;

  fsc_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_cmd(in_cmd), .pop(q_pop),
    .head(head), .not_empty(q_valid), .full(q_full)
  );

  fsc_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk(clk), .rst(rst), .cmd(head), .cmd_valid(q_valid), .cmd_pop(q_pop),
    .done(done), .visible(visible)
  );

  a_busy_full: assert property (@(posedge clk) disable iff (rst) busy == q_full)
    else $error("busy mismatch");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done || q_valid)
    else $error("done without queued work");
  a_unused_dropped: assert property (@(posedge clk) disable iff (rst)
    (start && kind_t'(kind) == KIND_NONE) |-> !push) else $error("unused kind queued");
endmodule
`default_nettype wire
